// ===== rtl/onr_pkg.sv =====
// Shared widths, codes and types of the next-use replacement core.
`timescale 1ns / 1ps
package onr_pkg;

    localparam int PAGE_W  = 63;
    localparam int NU_W    = 31;
    localparam int STAMP_W = 32;
    localparam int CNT_W   = 32;
    localparam int LIM_W   = 5;
    localparam int WORD_W  = PAGE_W + NU_W + STAMP_W;
    localparam int N_EVT   = 5;

    typedef logic [1:0] t_outcome;

    localparam t_outcome OUT_HIT    = 2'd0;
    localparam t_outcome OUT_FILL   = 2'd1;
    localparam t_outcome OUT_REPL   = 2'd2;
    localparam t_outcome OUT_BYPASS = 2'd3;

    localparam int EVT_RD_HIT  = 0;
    localparam int EVT_WR_HIT  = 1;
    localparam int EVT_RD_MISS = 2;
    localparam int EVT_WR_MISS = 3;
    localparam int EVT_BYPASS  = 4;

    localparam logic [LIM_W-1:0] LIM_RESET = 5'd16;

    typedef struct packed {
        logic clear;
        logic load;
    } t_scan_ctl;

    typedef struct packed {
        logic               hit;
        logic               have;
        logic [NU_W-1:0]    best_nu;
        logic [PAGE_W-1:0]  best_page;
    } t_scan_res;

endpackage

// ===== rtl/optimal_next_use_replacement_core.sv =====
// Top level: fully associative cache with furthest-next-use replacement.
//
// Command channel: present i_page, i_next_use and i_is_write with start high
// while busy is low; the access is taken at that clock edge and busy rises.
// Result channel: o_done pulses for one cycle with o_outcome, o_victim_page
// and the five running event counts; the receiver cannot hold it off.
// Configuration: i_cfg_we writes i_cfg_wdata into the ways-in-use limit
// (zero acts as one, values above WAYS act as WAYS); write only when idle.
// Ways are filled in index order and never emptied, so a fill count marks
// the occupied ways and no clearing pass is needed after reset.
// Sequencing: one shared compare unit walks the occupied ways one per cycle
// out of the entry RAM, then a drain state and a decide state follow; on an
// empty cache only the decide state is used. o_done follows in the cycle
// busy falls, when the next start may already be taken.
// Reset (i_rst_n low, synchronous) empties the cache, clears the stamp and
// event counters and sets the limit to 16.
`timescale 1ns / 1ps
module optimal_next_use_replacement_core #(
    parameter int WAYS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [onr_pkg::PAGE_W-1:0]          i_page,
    input  logic [onr_pkg::NU_W-1:0]            i_next_use,
    input  logic                                i_is_write,
    input  logic                                i_cfg_we,
    input  logic [onr_pkg::LIM_W-1:0]           i_cfg_wdata,
    output logic                                o_done,
    output onr_pkg::t_outcome                   o_outcome,
    output logic [onr_pkg::PAGE_W-1:0]          o_victim_page,
    output logic [onr_pkg::CNT_W-1:0]           o_read_hit_count,
    output logic [onr_pkg::CNT_W-1:0]           o_write_hit_count,
    output logic [onr_pkg::CNT_W-1:0]           o_read_miss_count,
    output logic [onr_pkg::CNT_W-1:0]           o_write_miss_count,
    output logic [onr_pkg::CNT_W-1:0]           o_bypass_count
);

    localparam int AW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CW = $clog2(WAYS + 1);
    localparam int LW = (CW > onr_pkg::LIM_W) ? CW : onr_pkg::LIM_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_DECIDE = 4'b1000
    } t_state;

    t_state                          r_state, n_state;
    logic [AW-1:0]                   r_addr, n_addr;
    logic [CW-1:0]                   r_count, n_count;
    logic                            r_rd_vld;
    logic [AW-1:0]                   r_rd_idx;
    logic [onr_pkg::LIM_W-1:0]       r_ways_in_use;
    logic [onr_pkg::STAMP_W-1:0]     r_stamp, n_stamp;
    logic [onr_pkg::CNT_W-1:0]       r_evt [onr_pkg::N_EVT];
    logic [onr_pkg::CNT_W-1:0]       n_evt [onr_pkg::N_EVT];
    logic [onr_pkg::PAGE_W-1:0]      r_page;
    logic [onr_pkg::NU_W-1:0]        r_nu;
    logic                            r_wr;
    logic                            r_done, n_done;
    onr_pkg::t_outcome               r_outcome, n_outcome;
    logic [onr_pkg::PAGE_W-1:0]      r_victim, n_victim;

    logic                            accept;
    logic                            last_addr;
    logic [LW-1:0]                   limit;
    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr;
    logic [onr_pkg::WORD_W-1:0]      ram_wdata;
    logic [onr_pkg::WORD_W-1:0]      ram_rdata;
    onr_pkg::t_scan_ctl              scan_ctl;
    onr_pkg::t_scan_res              scan_res;
    logic [AW-1:0]                   hit_way;
    logic [AW-1:0]                   best_way;
    logic [onr_pkg::STAMP_W-1:0]     stamp_next;

    assign accept    = start && !busy;
    assign busy      = (r_state != S_IDLE);
    assign last_addr = ((CW'(r_addr) + CW'(1)) == r_count);

    always_comb begin
        if (r_ways_in_use == '0) begin
            limit = LW'(1);
        end else if (LW'(r_ways_in_use) > LW'(WAYS)) begin
            limit = LW'(WAYS);
        end else begin
            limit = LW'(r_ways_in_use);
        end
    end

    assign stamp_next = (r_stamp == '1) ? r_stamp : r_stamp + 1'b1;

    always_comb begin
        scan_ctl.clear = accept;
        scan_ctl.load  = r_rd_vld;
    end

    onr_ram #(
        .WIDTH (onr_pkg::WORD_W),
        .DEPTH (WAYS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    onr_scan #(
        .AW (AW)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (scan_ctl),
        .i_idx      (r_rd_idx),
        .i_key      (r_page),
        .i_page     (ram_rdata[onr_pkg::WORD_W-1 -: onr_pkg::PAGE_W]),
        .i_nu       (ram_rdata[onr_pkg::STAMP_W +: onr_pkg::NU_W]),
        .i_stamp    (ram_rdata[onr_pkg::STAMP_W-1:0]),
        .o_res      (scan_res),
        .o_hit_way  (hit_way),
        .o_best_way (best_way)
    );

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_count   = r_count;
        n_stamp   = r_stamp;
        n_done    = 1'b0;
        n_outcome = r_outcome;
        n_victim  = r_victim;
        ram_we    = 1'b0;
        ram_waddr = r_count[AW-1:0];
        ram_wdata = {r_page, r_nu, r_stamp};
        for (int k = 0; k < onr_pkg::N_EVT; k++) begin
            n_evt[k] = r_evt[k];
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_addr  = '0;
                    n_state = (r_count == '0) ? S_DECIDE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (last_addr) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_state  = S_IDLE;
                n_done   = 1'b1;
                n_victim = '0;
                if (scan_res.hit) begin
                    if (r_wr) begin
                        n_evt[onr_pkg::EVT_WR_HIT] = (r_evt[onr_pkg::EVT_WR_HIT] == '1) ?
                            r_evt[onr_pkg::EVT_WR_HIT] : r_evt[onr_pkg::EVT_WR_HIT] + 1'b1;
                    end else begin
                        n_evt[onr_pkg::EVT_RD_HIT] = (r_evt[onr_pkg::EVT_RD_HIT] == '1) ?
                            r_evt[onr_pkg::EVT_RD_HIT] : r_evt[onr_pkg::EVT_RD_HIT] + 1'b1;
                    end
                    ram_we    = 1'b1;
                    ram_waddr = hit_way;
                    n_stamp   = stamp_next;
                    n_outcome = onr_pkg::OUT_HIT;
                end else begin
                    if (r_wr) begin
                        n_evt[onr_pkg::EVT_WR_MISS] = (r_evt[onr_pkg::EVT_WR_MISS] == '1) ?
                            r_evt[onr_pkg::EVT_WR_MISS] : r_evt[onr_pkg::EVT_WR_MISS] + 1'b1;
                    end else begin
                        n_evt[onr_pkg::EVT_RD_MISS] = (r_evt[onr_pkg::EVT_RD_MISS] == '1) ?
                            r_evt[onr_pkg::EVT_RD_MISS] : r_evt[onr_pkg::EVT_RD_MISS] + 1'b1;
                    end
                    if (LW'(r_count) < limit) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_count[AW-1:0];
                        n_count   = r_count + 1'b1;
                        n_stamp   = stamp_next;
                        n_outcome = onr_pkg::OUT_FILL;
                    end else if (scan_res.have && (scan_res.best_nu > r_nu)) begin
                        ram_we    = 1'b1;
                        ram_waddr = best_way;
                        n_stamp   = stamp_next;
                        n_victim  = scan_res.best_page;
                        n_outcome = onr_pkg::OUT_REPL;
                    end else begin
                        n_evt[onr_pkg::EVT_BYPASS] = (r_evt[onr_pkg::EVT_BYPASS] == '1) ?
                            r_evt[onr_pkg::EVT_BYPASS] : r_evt[onr_pkg::EVT_BYPASS] + 1'b1;
                        n_outcome = onr_pkg::OUT_BYPASS;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_stamp       <= '0;
            r_rd_vld      <= 1'b0;
            r_done        <= 1'b0;
            r_ways_in_use <= onr_pkg::LIM_RESET;
            for (int k = 0; k < onr_pkg::N_EVT; k++) begin
                r_evt[k] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_stamp  <= n_stamp;
            r_rd_vld <= (r_state == S_SCAN);
            r_done   <= n_done;
            if (i_cfg_we) begin
                r_ways_in_use <= i_cfg_wdata;
            end
            for (int k = 0; k < onr_pkg::N_EVT; k++) begin
                r_evt[k] <= n_evt[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_rd_idx  <= r_addr;
        r_outcome <= n_outcome;
        r_victim  <= n_victim;
        if (accept) begin
            r_page <= i_page;
            r_nu   <= i_next_use;
            r_wr   <= i_is_write;
        end
    end

    assign o_done             = r_done;
    assign o_outcome          = r_outcome;
    assign o_victim_page      = r_victim;
    assign o_read_hit_count   = r_evt[onr_pkg::EVT_RD_HIT];
    assign o_write_hit_count  = r_evt[onr_pkg::EVT_WR_HIT];
    assign o_read_miss_count  = r_evt[onr_pkg::EVT_RD_MISS];
    assign o_write_miss_count = r_evt[onr_pkg::EVT_WR_MISS];
    assign o_bypass_count     = r_evt[onr_pkg::EVT_BYPASS];

endmodule

// ===== rtl/onr_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module onr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/onr_scan.sv =====
// Shared tag-match and victim-search unit, fed one way per cycle.
`timescale 1ns / 1ps
module onr_scan #(
    parameter int AW = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  onr_pkg::t_scan_ctl           i_ctl,
    input  logic [AW-1:0]                i_idx,
    input  logic [onr_pkg::PAGE_W-1:0]   i_key,
    input  logic [onr_pkg::PAGE_W-1:0]   i_page,
    input  logic [onr_pkg::NU_W-1:0]     i_nu,
    input  logic [onr_pkg::STAMP_W-1:0]  i_stamp,
    output onr_pkg::t_scan_res           o_res,
    output logic [AW-1:0]                o_hit_way,
    output logic [AW-1:0]                o_best_way
);

    logic                        r_hit;
    logic                        r_have;
    logic [AW-1:0]               r_hit_way;
    logic [AW-1:0]               r_best_way;
    logic [onr_pkg::NU_W-1:0]    r_best_nu;
    logic [onr_pkg::STAMP_W-1:0] r_best_stamp;
    logic [onr_pkg::PAGE_W-1:0]  r_best_page;
    logic                        match;
    logic                        better;

    always_comb begin
        match  = !r_hit && (i_page == i_key);
        better = !r_have || (i_nu > r_best_nu) ||
                 ((i_nu == r_best_nu) && (i_stamp < r_best_stamp));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_hit  <= 1'b0;
            r_have <= 1'b0;
        end else if (i_ctl.load) begin
            if (match) begin
                r_hit <= 1'b1;
            end
            if (better) begin
                r_have <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && match) begin
            r_hit_way <= i_idx;
        end
        if (i_ctl.load && better) begin
            r_best_way   <= i_idx;
            r_best_nu    <= i_nu;
            r_best_stamp <= i_stamp;
            r_best_page  <= i_page;
        end
    end

    always_comb begin
        o_res.hit        = r_hit;
        o_res.have       = r_have;
        o_res.best_nu    = r_best_nu;
        o_res.best_page  = r_best_page;
    end

    assign o_hit_way  = r_hit_way;
    assign o_best_way = r_best_way;

endmodule

// ===== verif/optimal_next_use_replacement_core_tb.sv =====
// Self-checking testbench of the furthest-next-use replacement cache core.
`timescale 1ns / 1ps
module optimal_next_use_replacement_core_tb;

    localparam int WAYS        = 16;
    localparam int N_PHASE     = 9;
    localparam int PHASE_ITEMS = 183;
    localparam int STALL_LIMIT = 1000;

    localparam int PAGE_W  = onr_pkg::PAGE_W;
    localparam int NU_W    = onr_pkg::NU_W;
    localparam int STAMP_W = onr_pkg::STAMP_W;
    localparam int CNT_W   = onr_pkg::CNT_W;
    localparam int LIM_W   = onr_pkg::LIM_W;
    localparam int N_EVT   = onr_pkg::N_EVT;

    localparam logic [PAGE_W-1:0] PAGE_ONES = '1;
    localparam logic [PAGE_W-1:0] PAT_A     = 63'h2AAA_AAAA_AAAA_AAAA;
    localparam logic [PAGE_W-1:0] PAT_B     = ~PAT_A;
    localparam logic [PAGE_W-1:0] PAT_C     = 63'h0000_0000_FFFF_FFFF;
    localparam logic [PAGE_W-1:0] PAT_D     = 63'h7FFF_FFFF_0000_0000;
    localparam logic [NU_W-1:0]   NU_NEVER  = '1;

    typedef struct packed {
        onr_pkg::t_outcome           outcome;
        logic [PAGE_W-1:0]           victim;
        logic [N_EVT-1:0][CNT_W-1:0] counts;
    } t_access_result;

    class replacement_board;
        bit                  way_valid [WAYS];
        bit [PAGE_W-1:0]     way_page  [WAYS];
        bit [NU_W-1:0]       way_next  [WAYS];
        bit [STAMP_W-1:0]    way_stamp [WAYS];
        bit [STAMP_W-1:0]    stamp_ctr;
        bit [CNT_W-1:0]      evt_cnt   [N_EVT];
        bit [LIM_W-1:0]      limit_reg;
        t_access_result      expected_outcomes [$];
        string               evt_label [N_EVT];
        int unsigned         mismatches;
        int unsigned         result_no;

        function new();
            evt_label = '{"read hit count", "write hit count", "read miss count",
                          "write miss count", "bypass count"};
            foreach (way_valid[w])
                way_valid[w] = 1'b0;
            foreach (evt_cnt[k])
                evt_cnt[k] = '0;
            stamp_ctr  = '0;
            limit_reg  = onr_pkg::LIM_RESET;
            mismatches = 0;
            result_no  = 0;
        endfunction

        function void set_limit(bit [LIM_W-1:0] v);
            limit_reg = v;
        endfunction

        function int pending();
            return expected_outcomes.size();
        endfunction

        function void bump(int k);
            if (evt_cnt[k] != '1)
                evt_cnt[k]++;
        endfunction

        function bit [STAMP_W-1:0] take_stamp();
            bit [STAMP_W-1:0] s;
            s = stamp_ctr;
            if (stamp_ctr != '1)
                stamp_ctr++;
            return s;
        endfunction

        function void place(int w, bit [PAGE_W-1:0] pg, bit [NU_W-1:0] nu);
            way_valid[w] = 1'b1;
            way_page[w]  = pg;
            way_next[w]  = nu;
            way_stamp[w] = take_stamp();
        endfunction

        function void note_access(bit [PAGE_W-1:0] pg, bit [NU_W-1:0] nu, bit wr);
            t_access_result exp;
            int unsigned    eff;
            int unsigned    used;
            int             hit_w;
            int             free_w;
            int             best;
            eff    = (limit_reg == 0) ? 1 : ((limit_reg > WAYS) ? WAYS : limit_reg);
            used   = 0;
            hit_w  = -1;
            free_w = -1;
            exp.victim = '0;
            for (int w = 0; w < WAYS; w++) begin
                if (way_valid[w]) begin
                    used++;
                    if (hit_w < 0 && way_page[w] == pg)
                        hit_w = w;
                end else if (free_w < 0) begin
                    free_w = w;
                end
            end
            if (hit_w >= 0) begin
                bump(wr ? onr_pkg::EVT_WR_HIT : onr_pkg::EVT_RD_HIT);
                way_next[hit_w]  = nu;
                way_stamp[hit_w] = take_stamp();
                exp.outcome = onr_pkg::OUT_HIT;
            end else begin
                bump(wr ? onr_pkg::EVT_WR_MISS : onr_pkg::EVT_RD_MISS);
                if (used < eff && free_w >= 0) begin
                    place(free_w, pg, nu);
                    exp.outcome = onr_pkg::OUT_FILL;
                end else begin
                    best = -1;
                    for (int w = 0; w < WAYS; w++) begin
                        if (!way_valid[w])
                            continue;
                        if (best < 0 || way_next[w] > way_next[best] ||
                            (way_next[w] == way_next[best] &&
                             way_stamp[w] < way_stamp[best]))
                            best = w;
                    end
                    if (best >= 0 && way_next[best] > nu) begin
                        exp.victim = way_page[best];
                        place(best, pg, nu);
                        exp.outcome = onr_pkg::OUT_REPL;
                    end else begin
                        bump(onr_pkg::EVT_BYPASS);
                        exp.outcome = onr_pkg::OUT_BYPASS;
                    end
                end
            end
            for (int k = 0; k < N_EVT; k++)
                exp.counts[k] = evt_cnt[k];
            expected_outcomes = {expected_outcomes, exp};
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            mismatches++;
            $display("ERROR result %0d %s: got 0x%0h, expected 0x%0h",
                     result_no, what, got, want);
        endtask

        task check_outcome(onr_pkg::t_outcome oc, logic [PAGE_W-1:0] victim,
                           logic [N_EVT-1:0][CNT_W-1:0] counts);
            t_access_result exp;
            result_no++;
            if (expected_outcomes.size() == 0) begin
                report_mismatch("with no access outstanding", {62'd0, oc}, 64'd0);
            end else begin
                exp = expected_outcomes.pop_front();
                if (oc !== exp.outcome)
                    report_mismatch("outcome", {62'd0, oc}, {62'd0, exp.outcome});
                if (victim !== exp.victim)
                    report_mismatch("victim page", {1'b0, victim}, {1'b0, exp.victim});
                for (int k = 0; k < N_EVT; k++)
                    if (counts[k] !== exp.counts[k])
                        report_mismatch(evt_label[k], {32'd0, counts[k]},
                                        {32'd0, exp.counts[k]});
            end
        endtask
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [PAGE_W-1:0]   i_page;
    logic [NU_W-1:0]     i_next_use;
    logic                i_is_write;
    logic                i_cfg_we;
    logic [LIM_W-1:0]    i_cfg_wdata;
    logic                o_done;
    onr_pkg::t_outcome   o_outcome;
    logic [PAGE_W-1:0]   o_victim_page;
    logic [CNT_W-1:0]    o_read_hit_count;
    logic [CNT_W-1:0]    o_write_hit_count;
    logic [CNT_W-1:0]    o_read_miss_count;
    logic [CNT_W-1:0]    o_write_miss_count;
    logic [CNT_W-1:0]    o_bypass_count;

    replacement_board    board;
    bit                  no_idle = 1'b0;
    int unsigned         stall_cycles = 0;
    logic [PAGE_W-1:0]   page_pool [$];
    int unsigned         phase_limit [N_PHASE] = '{16, 1, 5, 31, 4, 0, 17, 9, 0};
    int unsigned         phase_pool  [N_PHASE] = '{24, 4, 10, 40, 8, 3, 30, 14, 20};

    optimal_next_use_replacement_core #(
        .WAYS(WAYS)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_page             (i_page),
        .i_next_use         (i_next_use),
        .i_is_write         (i_is_write),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_done             (o_done),
        .o_outcome          (o_outcome),
        .o_victim_page      (o_victim_page),
        .o_read_hit_count   (o_read_hit_count),
        .o_write_hit_count  (o_write_hit_count),
        .o_read_miss_count  (o_read_miss_count),
        .o_write_miss_count (o_write_miss_count),
        .o_bypass_count     (o_bypass_count)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1)
            board.check_outcome(o_outcome, o_victim_page,
                                {o_bypass_count, o_write_miss_count, o_read_miss_count,
                                 o_write_hit_count, o_read_hit_count});
    end

    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_done === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [PAGE_W-1:0] random_page();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[PAGE_W-1:0];
    endfunction

    function automatic logic [NU_W-1:0] pick_next_use();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(9))
            0, 1:    return NU_NEVER;
            2, 3, 4: return NU_W'($urandom_range(15));
            5:       return NU_NEVER - NU_W'($urandom_range(1, 8));
            default: return r[NU_W-1:0];
        endcase
    endfunction

    task automatic issue_access(input logic [PAGE_W-1:0] pg, input logic [NU_W-1:0] nu,
                                input logic wr);
        if (!no_idle && $urandom_range(99) < 35) begin
            start <= 1'b0;
            do @(posedge i_clk); while (busy !== 1'b0 || $urandom_range(99) < 35);
        end
        start      <= 1'b1;
        i_page     <= pg;
        i_next_use <= nu;
        i_is_write <= wr;
        do @(posedge i_clk); while (busy !== 1'b0);
        board.note_access(pg, nu, wr);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LIM_W-1:0] v);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_limit(v);
    endtask

    initial begin
        logic [LIM_W-1:0]  lim;
        logic [PAGE_W-1:0] flip;
        board = new();
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_page      <= '0;
        i_next_use  <= '0;
        i_is_write  <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fills and hits at the reset limit
        issue_access('0, NU_W'(5), 1'b0);
        issue_access(PAGE_ONES, NU_NEVER, 1'b1);
        issue_access('0, NU_W'(0), 1'b0);
        issue_access(PAGE_ONES, NU_W'(0), 1'b1);

        // full cache: bypass, equal never-used bypass, replacement, tie on next use
        write_limit(LIM_W'(2));
        issue_access(PAT_A, NU_W'(3), 1'b0);
        issue_access('0, NU_NEVER, 1'b1);
        issue_access(PAT_B, NU_NEVER, 1'b0);
        issue_access(PAT_B, NU_W'(10), 1'b1);
        issue_access(PAT_B, NU_W'(100), 1'b0);
        issue_access(PAGE_ONES, NU_W'(100), 1'b1);
        issue_access(PAT_A, NU_W'(50), 1'b0);

        // zero limit below occupancy
        write_limit(LIM_W'(0));
        issue_access(PAT_C, NU_W'(1), 1'b1);
        issue_access(PAT_D, NU_NEVER, 1'b0);

        // oversized limit clamps to all ways
        write_limit(LIM_W'(31));
        issue_access(PAT_D, NU_W'(7), 1'b0);
        for (int p = 1; p <= 5; p++)
            issue_access(PAGE_W'(p), NU_W'(7), p[0]);
        issue_access(PAT_C, NU_W'(7), 1'b0);

        for (int ph = 0; ph < N_PHASE; ph++) begin
            lim = (ph == N_PHASE - 1) ? LIM_W'($urandom_range(0, 31)) :
                                        LIM_W'(phase_limit[ph]);
            write_limit(lim);
            no_idle = (ph == 3);
            page_pool.delete();
            repeat (phase_pool[ph]) begin
                if (page_pool.size() != 0 && $urandom_range(9) == 0) begin
                    flip = '0;
                    flip[$urandom_range(PAGE_W - 1)] = 1'b1;
                    page_pool = {page_pool,
                                 page_pool[$urandom_range(page_pool.size() - 1)] ^ flip};
                end else begin
                    page_pool = {page_pool, random_page()};
                end
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(99) < 85)
                    issue_access(page_pool[$urandom_range(page_pool.size() - 1)],
                                 pick_next_use(), 1'($urandom_range(1)));
                else
                    issue_access(random_page(), pick_next_use(), 1'($urandom_range(1)));
            end
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (board.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== optimal_next_use_replacement_core.f =====
rtl/onr_pkg.sv
rtl/onr_ram.sv
rtl/onr_scan.sv
rtl/optimal_next_use_replacement_core.sv
verif/optimal_next_use_replacement_core_tb.sv
